// ----- rtl/spq_pkg.sv -----
// shared types, codes and defaults of the sorted priority queue
package spq_pkg;

	localparam int DEFAULT_CAPACITY = 16;
	localparam int VALUE_W          = 32;
	localparam int PRIO_W           = 16;
	localparam int STATUS_W         = 2;
	localparam int COUNT_OUT_W      = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
	} entry_t;

	// what a cell hands to its right neighbor
	typedef struct packed {
		logic   take;
		entry_t entry;
	} link_t;

	// broadcast to every cell
	typedef struct packed {
		logic   ins_en;
		logic   rem_en;
		entry_t entry;
	} cell_ctl_t;

endpackage

// ----- rtl/spq_in_if.sv -----
// command channel: one word per insert or remove
interface spq_in_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      op;
	logic signed [VALUE_W-1:0] item_value;
	logic signed [PRIO_W-1:0]  item_priority;

	modport source (output valid, output op, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input op, input item_value, input item_priority,
		output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
// result channel: one word per command
interface spq_out_if;
	import spq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic                      head_valid;
	logic signed [VALUE_W-1:0] head_value;
	logic signed [PRIO_W-1:0]  head_priority;
	logic [COUNT_OUT_W-1:0]    entry_count;

	modport source (output valid, output status, output head_valid, output head_value,
		output head_priority, output entry_count, input ready);
	modport sink (input valid, input status, input head_valid, input head_value,
		input head_priority, input entry_count, output ready);
endinterface

// ----- rtl/spq_cell.sv -----
// one slot of the sorted chain: compare, shift right on insert, shift left on remove
module spq_cell
	import spq_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] count,
	input  link_t         left_link,
	input  entry_t        right_entry,
	output link_t         link
);

	entry_t entry_q;
	logic   slot_valid;
	logic   take;

	assign slot_valid = count > CW'(INDEX);
	// strict compare keeps equal priorities in arrival order
	assign take = !slot_valid || (ctl.entry.prio > entry_q.prio);

	always_ff @(posedge clk) begin
		if (ctl.ins_en && take) begin
			entry_q <= left_link.take ? left_link.entry : ctl.entry;
		end else if (ctl.rem_en) begin
			entry_q <= right_entry;
		end
	end

	assign link.take  = take;
	assign link.entry = entry_q;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// sorted priority queue: a row of compare-and-shift cells with a registered result
// the result word of a command is valid in the cycle after the command is accepted
// throughput: one command per cycle while results are taken; every cell compares against
// the broadcast entry at once and loads from its left or right neighbor in the same cycle
// a result word waiting at the output still lets the next command in when it is taken
// reset: arst_n clears the entry count and the result valid flag; slot contents are not reset
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_in_if.sink    cmd,
	spq_out_if.source result
);

	localparam int CW = $clog2(CAPACITY + 1);

	// queue occupancy
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          full;
	logic          empty;

	// handshake
	logic accept;
	logic out_valid_q;

	// cell chain
	cell_ctl_t ctl;
	link_t     links [CAPACITY];
	link_t     no_link;
	entry_t    new_entry;
	entry_t    zero_entry;

	// next result word
	logic [STATUS_W-1:0] status_next;
	entry_t              head_next;
	logic                head_valid_next;

	// result registers
	logic [STATUS_W-1:0]       status_q;
	logic                      head_valid_q;
	logic signed [VALUE_W-1:0] head_value_q;
	logic signed [PRIO_W-1:0]  head_priority_q;
	logic [CW-1:0]             entry_count_q;

	// the output register frees up in the same cycle its word is taken
	assign cmd.ready = !out_valid_q || result.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign full  = count_q == CW'(CAPACITY);
	assign empty = count_q == '0;

	assign new_entry.value = cmd.item_value;
	assign new_entry.prio  = cmd.item_priority;
	assign zero_entry      = '0;
	assign no_link         = '0;

	assign ctl.ins_en = accept && (cmd.op == OP_INSERT) && !full;
	assign ctl.rem_en = accept && (cmd.op == OP_REMOVE) && !empty;
	assign ctl.entry  = new_entry;

	// each cell sees its left neighbor's link and its right neighbor's entry
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t  left_in;
		entry_t right_in;

		if (i == 0) begin : g_first
			assign left_in = no_link;
		end else begin : g_mid_left
			assign left_in = links[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_in = zero_entry;
		end else begin : g_mid_right
			assign right_in = links[i+1].entry;
		end

		spq_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.left_link   (left_in),
			.right_entry (right_in),
			.link        (links[i])
		);
	end

	// status, count and head entry as they stand after this command
	always_comb begin
		status_next = ST_DONE;
		count_next  = count_q;
		head_next   = links[0].entry;
		if (cmd.op == OP_INSERT) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				count_next = count_q + CW'(1);
				// the new entry is the head when the first cell takes it
				if (links[0].take) begin
					head_next = new_entry;
				end
			end
		end else begin
			if (empty) begin
				status_next = ST_EMPTY;
			end else begin
				count_next = count_q - CW'(1);
				head_next  = links[1].entry;
			end
		end
		head_valid_next = count_next != '0;
		if (!head_valid_next) begin
			head_next = zero_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted command
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q        <= status_next;
			head_valid_q    <= head_valid_next;
			head_value_q    <= head_next.value;
			head_priority_q <= head_next.prio;
			entry_count_q   <= count_next;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = status_q;
	assign result.head_valid    = head_valid_q;
	assign result.head_value    = head_value_q;
	assign result.head_priority = head_priority_q;

	// entry count is reported in five bits, masked when the capacity needs more
	if (CW >= COUNT_OUT_W) begin : g_cnt_trunc
		assign result.entry_count = entry_count_q[COUNT_OUT_W-1:0];
	end else begin : g_cnt_ext
		assign result.entry_count = {{(COUNT_OUT_W-CW){1'b0}}, entry_count_q};
	end

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the sorted priority queue: directed and random traffic
module tb_top
	import spq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = DEFAULT_CAPACITY;

	// one expected result word, field for field as the result channel carries it
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic                      head_valid;
		logic signed [VALUE_W-1:0] head_value;
		logic signed [PRIO_W-1:0]  head_priority;
		logic [COUNT_OUT_W-1:0]    entry_count;
	} queue_result_t;

	logic clk;
	logic arst_n;

	spq_in_if  cmd_ch ();
	spq_out_if res_ch ();

	sorted_priority_queue #(
		.CAPACITY(QDEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.result(res_ch)
	);

	// shadow copy of the queue contents, head at index 0
	entry_t shadow_slots [QDEPTH];
	int     shadow_count;

	queue_result_t pending_results [$];
	int            mismatches;

	// when set, neither side idles: full-rate back-to-back stretch
	bit calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// applies one command to the shadow queue and returns the word the block should send
	function automatic queue_result_t queue_apply(input logic op,
		input logic signed [VALUE_W-1:0] val, input logic signed [PRIO_W-1:0] prio);
		queue_result_t r;
		int pos;
		r = '0;
		r.status = ST_DONE;
		if (op == OP_INSERT) begin
			if (shadow_count >= QDEPTH) begin
				// full queue: word dropped, contents untouched
				r.status = ST_FULL;
			end else begin
				// new entry goes behind every entry of equal or higher priority,
				// so equal priorities leave in arrival order
				pos = 0;
				while (pos < shadow_count && $signed(shadow_slots[pos].prio) >= $signed(prio))
					pos++;
				for (int i = shadow_count; i > pos; i--)
					shadow_slots[i] = shadow_slots[i-1];
				shadow_slots[pos].value = val;
				shadow_slots[pos].prio  = prio;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			// remove on empty queue leaves everything as it was
			r.status = ST_EMPTY;
		end else begin
			for (int i = 0; i + 1 < shadow_count; i++)
				shadow_slots[i] = shadow_slots[i+1];
			shadow_count--;
		end
		// empty queue reports a zero head
		if (shadow_count > 0) begin
			r.head_valid    = 1'b1;
			r.head_value    = shadow_slots[0].value;
			r.head_priority = shadow_slots[0].prio;
		end
		r.entry_count = shadow_count[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// one line per mismatch, printing capped so a broken block cannot flood the log
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < 40)
			$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// result sink: random stalls on ready
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// watches both channels at each edge; a result is checked before the command
	// taken at the same edge is predicted, since a result is never same-cycle
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected word, status", 64'(res_ch.status), 64'(0));
				end else begin
					want = pending_results.pop_front();
					if (res_ch.status !== want.status)
						report_mismatch("status", 64'(res_ch.status), 64'(want.status));
					if (res_ch.head_valid !== want.head_valid)
						report_mismatch("head_valid", 64'(res_ch.head_valid),
							64'(want.head_valid));
					if (res_ch.head_value !== want.head_value)
						report_mismatch("head_value", 64'(res_ch.head_value),
							64'(want.head_value));
					if (res_ch.head_priority !== want.head_priority)
						report_mismatch("head_priority", 64'(res_ch.head_priority),
							64'(want.head_priority));
					if (res_ch.entry_count !== want.entry_count)
						report_mismatch("entry_count", 64'(res_ch.entry_count),
							64'(want.entry_count));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				pending_results.push_back(queue_apply(cmd_ch.op, cmd_ch.item_value,
					cmd_ch.item_priority));
		end
	end

	// presents one command word and returns at the edge where it is taken;
	// valid stays high into the next word when there is no gap
	task automatic send_cmd(input logic op, input logic signed [VALUE_W-1:0] val,
		input logic signed [PRIO_W-1:0] prio);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.op            <= op;
		cmd_ch.item_value    <= val;
		cmd_ch.item_priority <= prio;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// sender holds off until every outstanding result word has come back
	task automatic wait_results_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// remove with nothing stored; payload fields are don't-care on remove
	task automatic test_remove_empty();
		send_cmd(OP_REMOVE, $urandom(), PRIO_W'($urandom()));
	endtask

	// extremes of value and priority, ties at head, middle and tail, and
	// inserts of the lowest priority that must land at the tail
	task automatic test_order_and_extremes();
		send_cmd(OP_INSERT, 32'sd5, 16'sd0);
		send_cmd(OP_INSERT, -32'sd1, 16'sd0);
		send_cmd(OP_INSERT, 32'h7fff_ffff, 16'h7fff);
		send_cmd(OP_INSERT, 32'h8000_0000, 16'h8000);
		send_cmd(OP_INSERT, 32'sd7, 16'h8000);
		send_cmd(OP_INSERT, 32'sd3, 16'sd0);
		send_cmd(OP_INSERT, 32'sd9, 16'h7fff);
	endtask

	// top the queue up to capacity, then one insert that must be dropped
	task automatic test_insert_full();
		repeat (QDEPTH - 7)
			send_cmd(OP_INSERT, $urandom(), PRIO_W'($urandom()));
		send_cmd(OP_INSERT, 32'h1234_5678, 16'h7fff);
	endtask

	// a few head removals off a full queue
	task automatic test_remove_head();
		repeat (3)
			send_cmd(OP_REMOVE, $urandom(), PRIO_W'($urandom()));
	endtask

	// random mix; narrow priorities force many ties, wide ones hit the extremes now and then
	task automatic test_random_traffic(input int count, input int insert_pct, input bit narrow);
		logic                      op;
		logic signed [PRIO_W-1:0]  prio;
		repeat (count) begin
			op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
			if (narrow)
				prio = PRIO_W'($urandom_range(0, 4)) - 16'sd2;
			else if ($urandom_range(0, 15) == 0)
				prio = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			else
				prio = PRIO_W'($urandom());
			send_cmd(op, $urandom(), prio);
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		cmd_ch.valid         <= 1'b0;
		cmd_ch.op            <= OP_INSERT;
		cmd_ch.item_value    <= '0;
		cmd_ch.item_priority <= '0;
		shadow_count = 0;
		mismatches   = 0;
		calm         = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_remove_empty();
		test_order_and_extremes();
		test_insert_full();
		test_remove_head();
		wait_results_drained();

		test_random_traffic(100, 50, 1'b0);
		test_random_traffic(100, 75, 1'b1);
		wait_results_drained();
		test_random_traffic(80, 25, 1'b0);
		// no idling on either side for a while
		calm = 1'b1;
		test_random_traffic(80, 55, 1'b1);
		calm = 1'b0;
		test_random_traffic(40, 50, 1'b0);

		wait_results_drained();
		// a few more cycles to catch any stray result word
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
